/* src/fpd_pkg.sv */
package fpd_pkg;

  localparam logic [31:0] SGN_BIT   = 32'h8000_0000;
  localparam logic [31:0] EXP_FIELD = 32'h7f80_0000;
  localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
  localparam logic [31:0] DEF_NAN   = 32'hffc0_0000;
  localparam int          QBITS     = 25;

  // word handed from one divider cell to the next
  typedef struct packed {
    logic [24:0] rem;
    logic [24:0] y;
    logic [24:0] q;
  } div_word_t;

endpackage

/* src/fpd_cell.sv */
module fpd_cell (
  input  logic              clk,
  input  logic              load,
  input  fpd_pkg::div_word_t din,
  output fpd_pkg::div_word_t dout
);
  logic [24:0] diff;
  logic        ge;

  // compute one restoring step
  assign ge   = din.rem >= din.y;
  assign diff = ge ? (din.rem - din.y) : din.rem;

  // hold the step result for the next cell
  always_ff @(posedge clk) begin
    if (load) begin
      dout.rem <= {diff[23:0], 1'b0};
      dout.y   <= din.y;
      dout.q   <= {din.q[23:0], ge};
    end
  end
endmodule

/* src/fpd_unpack.sv */
module fpd_unpack (
  input  logic [31:0] word,
  output logic [23:0] sig,
  output logic signed [9:0] expo
);
  logic [4:0] lz;
  logic [23:0] raw;

  // normalize a subnormal significand by a leading zero count
  always_comb begin
    raw = {1'b0, word[22:0]};
    lz  = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (raw[i]) lz = 5'(23 - i);
    end
    if (word[30:23] == 8'd0) begin
      sig  = raw << lz;
      expo = 10'sd1 - $signed({5'd0, lz});
    end else begin
      sig  = {1'b1, word[22:0]};
      expo = $signed({2'd0, word[30:23]});
    end
  end
endmodule

/* src/fp32_divider_top.sv */
// channel  | ports                         | handshake
// input    | dividend[31:0], divisor[31:0] | start & !busy
// result   | quotient[31:0]                | done, one cycle
// A word passes a pre-step register, a row of 25 divider cells, each
// resolving one quotient bit and passing the word along one cell a cycle,
// and a rounding step whose result is registered at the output.
// Special operands take the same path. Reset clears control only.
// The receiver cannot stall; busy stays high until done.
module fp32_divider_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);
  localparam int N = fpd_pkg::QBITS;

  logic [23:0] sa, sb;
  logic signed [9:0] ea, eb;
  logic [30:0] ma, mb;
  logic        spec;
  logic [31:0] spec_val;
  logic        go;
  logic [N:0]  vld;
  logic        spec_r;
  logic [31:0] spec_val_r;
  logic [31:0] sign_r;
  logic signed [10:0] er_r;
  fpd_pkg::div_word_t chain [N+1];

  fpd_unpack u_ua (.word(dividend), .sig(sa), .expo(ea));
  fpd_unpack u_ub (.word(divisor),  .sig(sb), .expo(eb));

  assign go = start && !busy;
  assign ma = dividend[30:0];
  assign mb = divisor[30:0];

  // classify special operands
  always_comb begin
    spec = 1'b1;
    spec_val = 32'd0;
    if (ma > 31'h7f80_0000) spec_val = dividend | fpd_pkg::QUIET_BIT;
    else if (mb > 31'h7f80_0000) spec_val = divisor | fpd_pkg::QUIET_BIT;
    else if ((ma == 31'd0 && mb == 31'd0) ||
             (ma == 31'h7f80_0000 && mb == 31'h7f80_0000)) spec_val = fpd_pkg::DEF_NAN;
    else if (ma == 31'd0 || mb == 31'h7f80_0000)
      spec_val = (dividend ^ divisor) & fpd_pkg::SGN_BIT;
    else if (mb == 31'd0 || ma == 31'h7f80_0000)
      spec_val = ((dividend ^ divisor) & fpd_pkg::SGN_BIT) | fpd_pkg::EXP_FIELD;
    else spec = 1'b0;
  end

  // load the head of the chain on start
  always_ff @(posedge clk) begin
    if (go) begin
      chain[0].y   <= {1'b0, sb};
      chain[0].q   <= '0;
      chain[0].rem <= (sa < sb) ? {sa, 1'b0} : {1'b0, sa};
      er_r <= 11'(ea) - 11'(eb) + 11'sd127 - ((sa < sb) ? 11'sd1 : 11'sd0);
      spec_r <= spec;
      spec_val_r <= spec_val;
      sign_r <= (dividend ^ divisor) & fpd_pkg::SGN_BIT;
    end
  end

  // advance the word through the cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    fpd_cell u_cell (.clk(clk), .load(vld[g]), .din(chain[g]), .dout(chain[g+1]));
  end

  // track the word position
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[N-1:0], go};
    end
  end

  logic [24:0] q;
  logic        sticky, sticky2;
  logic [24:0] qs;
  logic [24:0] smask;
  logic [4:0]  sh;
  logic [31:0] res;
  logic [24:0] qr;

  // round and pack; a rounding carry bumps the exponent
  always_comb begin
    q = chain[N].q;
    sticky = chain[N].rem != 25'd0;
    sh = 5'd0;
    smask = '0;
    qs = q;
    sticky2 = sticky;
    qr = '0;
    res = '0;
    if (er_r >= 11'sd1 && er_r <= 11'sd254) begin
      qr = {1'b0, q[24:1]} + 25'(q[0] & (sticky | q[1]));
      res = {1'b0, er_r[7:0], 23'd0} + {7'd0, qr} - 32'h0080_0000;
    end else if (er_r > 11'sd254) begin
      res = fpd_pkg::EXP_FIELD;
    end else begin
      sh = (er_r < -11'sd24) ? 5'd25 : 5'(11'sd1 - er_r);
      smask = (25'd1 << sh) - 25'd1;
      sticky2 = sticky | ((q & smask) != 25'd0);
      qs = q >> sh;
      qr = {1'b0, qs[24:1]} + 25'(qs[0] & (sticky2 | qs[1]));
      res = {7'd0, qr};
    end
  end

  // register the result word and pulse done for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= vld[N];
      if (go) busy <= 1'b1;
      else if (vld[N]) busy <= 1'b0;
    end
    if (vld[N]) quotient <= spec_r ? spec_val_r : (res | sign_r);
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(vld))
    else $error("more than one word in the chain");
  a_done: assert property (@(posedge clk) disable iff (rst) done |-> !vld[N])
    else $error("done overlaps chain exit");
  a_busy: assert property (@(posedge clk) disable iff (rst) (vld != '0) |-> busy)
    else $error("word in flight while not busy");
endmodule

/* tb/sv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        start;
  logic [31:0] dividend;
  logic [31:0] divisor;
  logic        busy;
  logic        done;
  logic [31:0] quotient;

  fp32_divider_top uut (
    .clk(clk), .rst(rst), .start(start), .dividend(dividend), .divisor(divisor),
    .busy(busy), .done(done), .quotient(quotient)
  );

  localparam int WATCHDOG_LIMIT = 2000;

  logic [63:0] pending_ops[$];
  logic [31:0] expected_quotients[$];
  int          error_count = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          idle_cycles = 0;
  bit          stim_done = 0;
  int          burst_left = 0;
  int          gap_left = 0;

  // compute the rounded binary32 quotient
  function automatic logic [31:0] fp_quotient(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] sgn, ma, mb, x, y, q, rnd, odd, sticky;
    int ea, eb, er, i, sh;
    sgn = (a ^ b) & fpd_pkg::SGN_BIT;
    ma = a & ~fpd_pkg::SGN_BIT;
    mb = b & ~fpd_pkg::SGN_BIT;
    ea = int'(a[30:23]);
    eb = int'(b[30:23]);
    if (ma > fpd_pkg::EXP_FIELD) return a | fpd_pkg::QUIET_BIT;
    if (mb > fpd_pkg::EXP_FIELD) return b | fpd_pkg::QUIET_BIT;
    if ((ma == 0 && mb == 0) || (ma == fpd_pkg::EXP_FIELD && mb == fpd_pkg::EXP_FIELD))
      return fpd_pkg::DEF_NAN;
    if (ma == 0 || mb == fpd_pkg::EXP_FIELD) return sgn;
    if (mb == 0 || ma == fpd_pkg::EXP_FIELD) return sgn | fpd_pkg::EXP_FIELD;
    // normalize subnormal significands
    if (ea == 0) begin
      x = ma;
      ea = 1;
      while (x[23] == 1'b0) begin
        x = x << 1;
        ea--;
      end
    end else begin
      x = {9'd1, ma[22:0]};
    end
    if (eb == 0) begin
      y = mb;
      eb = 1;
      while (y[23] == 1'b0) begin
        y = y << 1;
        eb--;
      end
    end else begin
      y = {9'd1, mb[22:0]};
    end
    er = ea - eb + 127;
    if (x < y) begin
      x = x << 1;
      er--;
    end
    q = 0;
    for (i = 0; i < fpd_pkg::QBITS; i++) begin
      q = q << 1;
      if (x >= y) begin
        x = x - y;
        q[0] = 1'b1;
      end
      x = x << 1;
    end
    sticky = (x != 0) ? 32'd1 : 32'd0;
    if (er >= 1 && er <= 254) begin
      rnd = q & 1;
      odd = (q >> 1) & 1;
      q = (q >> 1) + (rnd & (sticky | odd));
      q = (32'(er) << 23) + (q - 32'h0080_0000);
    end else if (er > 254) begin
      q = fpd_pkg::EXP_FIELD;
    end else begin
      sh = 1 - er;
      if (sh > fpd_pkg::QBITS) sh = fpd_pkg::QBITS;
      if ((q & ((32'd1 << sh) - 1)) != 0) sticky = 1;
      q = q >> sh;
      rnd = q & 1;
      odd = (q >> 1) & 1;
      q = (q >> 1) + (rnd & (sticky | odd));
    end
    return q | sgn;
  endfunction

  // pick an operand biased toward interesting classes
  function automatic logic [31:0] pick_operand();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: w[30:23] = 8'h00;
      1: w[30:23] = 8'hff;
      2: w[30:0] = 31'd0;
      3: w[30:23] = 8'(w[30:23] % 8);
      4: w[30:23] = 8'(8'hf7 + w[25:23]);
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    logic [31:0] edge_vals[12];
    int n;
    edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
                  32'h7fc0_0001, 32'hff80_0001, 32'h0000_0001, 32'h007f_ffff,
                  32'h0080_0000, 32'h7f7f_ffff, 32'h3f80_0000, 32'hbfff_ffff};
    // directed: pairs of edge values, then over/underflow extremes and NaN operands
    for (int i = 0; i < 12; i += 2) begin
      pending_ops.push_back({edge_vals[i], edge_vals[i+1]});
      pending_ops.push_back({edge_vals[i+1], edge_vals[(i+5) % 12]});
    end
    pending_ops.push_back({32'h7f7f_ffff, 32'h0000_0001});
    pending_ops.push_back({32'h0000_0001, 32'h7f7f_ffff});
    pending_ops.push_back({32'h0080_0000, 32'h3fff_ffff});
    pending_ops.push_back({32'h7fa0_0000, 32'h7fc0_0000});
    pending_ops.push_back({32'h3f80_0000, 32'h7f80_0001});
    n = 950;
    for (int i = 0; i < n; i++) pending_ops.push_back({pick_operand(), pick_operand()});
  end

  // reset and drive
  initial begin
    rst = 1'b1;
    start = 1'b0;
    dividend = '0;
    divisor = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: bursts of words with random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_quotients.push_back(fp_quotient(dividend, divisor));
        words_sent++;
      end
      if (start && busy) begin
        // hold the word until accepted
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        {dividend, divisor} <= pending_ops.pop_front();
        start <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
        end else begin
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 :
                                           $urandom_range(1, 40);
        end
      end else begin
        start <= 1'b0;
        stim_done = 1;
      end
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_quotients.size() == 0) begin
        $error("quotient: unexpected word %h", quotient);
        error_count++;
      end else begin
        logic [31:0] exp_q;
        exp_q = expected_quotients.pop_front();
        if (quotient !== exp_q) begin
          $error("quotient mismatch: expected %h actual %h", exp_q, quotient);
          error_count++;
        end
        words_checked++;
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if (!rst) begin
      if (done || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: timeout, %0d words outstanding", expected_quotients.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done && !start);
    wait (expected_quotients.size() == 0);
    repeat (40) @(posedge clk);
    $display("tb: %0d divisions sent, %0d quotients checked", words_sent, words_checked);
    $display("tb: edge operands, NaN/inf/zero/subnormal classes and random pairs covered");
    if (error_count == 0 && expected_quotients.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* fp32_divider_top.f */
src/fpd_pkg.sv
src/fpd_cell.sv
src/fpd_unpack.sv
src/fp32_divider_top.sv
tb/sv/tb.sv
